// ----- rtl/category_max_weight_table_assert.svh -----
// Assertion macros for the checker file.
`ifndef CATEGORY_MAX_WEIGHT_TABLE_ASSERT_SVH
`define CATEGORY_MAX_WEIGHT_TABLE_ASSERT_SVH

// Checked outside reset only.
`define CMWT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cmwt: assertion failed");

// Checked at every edge, reset included.
`define CMWT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("cmwt: assertion failed");

`endif

// ----- rtl/cmwt_pkg.sv -----
// Package for the category maximum-weight table: constants, payload types, state and register codes.
package cmwt_pkg;

	localparam int MAX_ENTRIES    = 16;
	localparam int NUM_CATEGORIES = 10;
	localparam int CATG_BITS      = 10;

	localparam int ID_W   = 8;
	localparam int WGT_W  = 32;
	localparam int CFG_W  = 32;
	localparam int CNT_OUT_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CATG_IDX_W = $clog2(CATG_BITS);

	// ids at or above this are never enabled
	localparam int ID_LIMIT_I = (NUM_CATEGORIES < CATG_BITS) ? NUM_CATEGORIES : CATG_BITS;
	localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(ID_LIMIT_I);

	localparam logic [WGT_W-1:0] STOP_THR_RESET = WGT_W'(100);

	typedef struct packed {
		logic             new_search;
		logic [ID_W-1:0]  category_id;
		logic [WGT_W-1:0] weight;
	} hit_t;

	typedef struct packed {
		logic                 accepted;
		logic [WGT_W-1:0]     stored_weight;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 overflow;
		logic                 stop_search;
	} res_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [WGT_W-1:0] weight;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED   = 1'b0,
		REG_THRESHOLD = 1'b1
	} cfg_reg_t;

endpackage

// ----- rtl/cmwt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module cmwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/category_max_weight_table.sv -----
// Top level of the category maximum-weight table.
// Keeps up to MAX_ENTRIES distinct category ids with the largest weight seen for each since
// the last new search, held in one entry RAM (id and weight per word). A hit beat is taken
// only while the block is idle; it then searches the table one entry per cycle through the
// RAM's single read port and stops reading early once its id turns up. The result beat sits
// in an output register, so the next hit may be taken while it waits. Hits with a zero
// weight, a disabled category or an id of NUM_CATEGORIES or more change nothing but still
// report the weight held for their id. No clearing pass is needed after reset.
module category_max_weight_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                hit_valid,
	output logic                                hit_ready,
	input  cmwt_pkg::hit_t                      hit,
	output logic                                res_valid,
	input  logic                                res_ready,
	output cmwt_pkg::res_t                      res,
	input  logic                                cfg_en,
	input  logic [cmwt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmwt_pkg::CFG_W-1:0]          cfg_data
);
	import cmwt_pkg::*;

	state_t state_q, state_nxt;

	logic [CATG_BITS-1:0] en_mask_q;
	logic [WGT_W-1:0]     thr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 stop_q;
	logic                 res_valid_q;
	res_t                 res_q;

	hit_t                 hit_q;
	logic [CNT_W-1:0]     iss_idx_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     pend_idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     slot_q;
	logic [WGT_W-1:0]     old_w_q;

	logic                 issue;
	logic                 scan_hit;
	logic                 can_push;
	logic                 upd_go;

	logic [ENTRY_W-1:0]   rd_data;
	entry_t               rd_entry;
	entry_t               wr_entry;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;

	logic                 id_en;
	logic                 en_hit;
	logic                 room;
	logic                 raise;
	logic                 append;
	logic                 accepted;
	logic [WGT_W-1:0]     max_w;
	logic [WGT_W-1:0]     held;
	logic [CNT_W-1:0]     cnt_nxt;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
	logic                 stop_nxt;

	// ---- entry memory ----
	assign rd_entry = entry_t'(rd_data);

	cmwt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (ENTRY_W'(wr_entry)),
		.rd_en   (issue),
		.rd_addr (iss_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// ---- control ----
	assign scan_hit = pend_s1 && (rd_entry.id == hit_q.category_id);
	assign can_push = !res_valid_q || res_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (hit_valid) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_hit || !issue) begin
					state_nxt = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (can_push) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		hit_ready = 1'b0;
		issue     = 1'b0;
		upd_go    = 1'b0;
		unique case (state_q)
			S_IDLE:   hit_ready = 1'b1;
			// stop reading once the id turns up
			S_SCAN:   issue = (iss_idx_q < count_q) && !scan_hit;
			S_UPDATE: upd_go = can_push;
			default: ;
		endcase
	end

	// ---- update decision ----
	assign id_en  = (hit_q.category_id < ID_LIMIT) ?
		en_mask_q[hit_q.category_id[CATG_IDX_W-1:0]] : 1'b0;
	assign en_hit = (hit_q.weight != '0) && id_en;
	assign room   = count_q < CNT_W'(MAX_ENTRIES);
	assign max_w  = (old_w_q < hit_q.weight) ? hit_q.weight : old_w_q;
	assign raise  = en_hit && found_q && (old_w_q < hit_q.weight);
	assign append = en_hit && !found_q && room;
	assign accepted = en_hit && (found_q || room);

	always_comb begin
		if (found_q) begin
			held = en_hit ? max_w : old_w_q;
		end else if (append) begin
			held = hit_q.weight;
		end else begin
			held = '0;
		end
	end

	assign cnt_nxt  = count_q + CNT_W'(append);
	assign cnt_ext  = {{CNT_OUT_W{1'b0}}, cnt_nxt};
	assign stop_nxt = stop_q || (accepted && (held >= thr_q));

	assign wr_en          = upd_go && (raise || append);
	assign wr_addr        = found_q ? slot_q : count_q[IDX_W-1:0];
	assign wr_entry.id    = hit_q.category_id;
	assign wr_entry.weight = hit_q.weight;

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			en_mask_q   <= '0;
			thr_q       <= STOP_THR_RESET;
			count_q     <= '0;
			stop_q      <= 1'b0;
			res_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			pend_s1 <= issue;
			if (cfg_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ENABLED:   en_mask_q <= cfg_data[CATG_BITS-1:0];
					REG_THRESHOLD: thr_q     <= cfg_data[WGT_W-1:0];
					default: ;
				endcase
			end
			if (hit_valid && hit_ready && hit.new_search) begin
				count_q <= '0;
				stop_q  <= 1'b0;
			end else if (upd_go) begin
				count_q <= cnt_nxt;
				stop_q  <= stop_nxt;
			end
			if (upd_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (hit_valid && hit_ready) begin
			hit_q     <= hit;
			iss_idx_q <= '0;
		end else if (issue) begin
			iss_idx_q <= iss_idx_q + CNT_W'(1);
		end
		pend_idx_s1 <= iss_idx_q[IDX_W-1:0];
		if (state_q == S_SCAN) begin
			found_q <= scan_hit;
			slot_q  <= pend_idx_s1;
			old_w_q <= rd_entry.weight;
		end
		if (upd_go) begin
			res_q.accepted      <= accepted;
			res_q.stored_weight <= held;
			res_q.entry_count   <= cnt_ext[CNT_OUT_W-1:0];
			res_q.overflow      <= en_hit && !found_q && !room;
			res_q.stop_search   <= stop_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/cmwt_checker.sv -----
// Port-level checker for the category maximum-weight table, bound to the top level.
`include "category_max_weight_table_assert.svh"

module cmwt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           hit_valid,
	input logic                           hit_ready,
	input cmwt_pkg::hit_t                 hit,
	input logic                           res_valid,
	input logic                           res_ready,
	input cmwt_pkg::res_t                 res,
	input logic                           cfg_en,
	input logic [cmwt_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cmwt_pkg::CFG_W-1:0]     cfg_data
);
	import cmwt_pkg::*;

	// a stalled result beat holds
	`CMWT_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res))

	// one hit at a time: busy right after a hit beat
	`CMWT_ASSERT(a_busy_after_hit, hit_valid && hit_ready |=> !hit_ready)

	// overflow and acceptance exclude each other
	`CMWT_ASSERT(a_ovf_not_acc, res_valid && res.overflow |-> !res.accepted)

	// an accepted hit always leaves a nonzero weight held
	`CMWT_ASSERT(a_acc_weight, res_valid && res.accepted |-> res.stored_weight != '0)

	// a reset cycle leaves no result beat behind it
	`CMWT_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !res_valid)

endmodule

bind category_max_weight_table cmwt_checker u_cmwt_checker (.*);

// ----- tb/tb_category_max_weight_table.sv -----
// Testbench for the category maximum-weight table: table scoreboard, beat drivers and checks.
`timescale 1ns / 100ps

module tb_category_max_weight_table;
	import cmwt_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_CAP   = 40;

	// Tracks the category table and queues the result due for every hit taken.
	class hit_board;
		bit [ID_W-1:0]      ids [MAX_ENTRIES];
		bit [WGT_W-1:0]     wts [MAX_ENTRIES];
		int unsigned        held_cnt;
		bit                 stopped;
		bit [CATG_BITS-1:0] cat_mask;
		bit [WGT_W-1:0]     stop_thr;
		res_t               due_results[$];
		int                 errors, n_hits, n_results, n_acc, n_stop, n_oor;

		function new();
			held_cnt = 0;
			stopped  = 1'b0;
			cat_mask = '0;
			stop_thr = STOP_THR_RESET;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_ENABLED:   cat_mask = d[CATG_BITS-1:0];
				REG_THRESHOLD: stop_thr = d[WGT_W-1:0];
				default: ;
			endcase
		endfunction

		function res_t apply_hit(hit_t h);
			res_t r;
			int   slot;
			bit   en;
			r = '0;
			if (h.new_search) begin
				held_cnt = 0;
				stopped  = 1'b0;
			end
			slot = -1;
			for (int i = 0; i < held_cnt && i < MAX_ENTRIES; i++)
				if (slot < 0 && ids[i] == h.category_id)
					slot = i;
			en = (h.category_id < NUM_CATEGORIES) && cat_mask[h.category_id[3:0]];
			if (h.weight != 0 && en) begin
				if (slot >= 0) begin
					if (wts[slot] < h.weight)
						wts[slot] = h.weight;
					r.accepted = 1'b1;
				end else if (held_cnt < MAX_ENTRIES) begin
					slot       = held_cnt;
					ids[slot]  = h.category_id;
					wts[slot]  = h.weight;
					held_cnt++;
					r.accepted = 1'b1;
				end else begin
					r.overflow = 1'b1;
				end
				if (r.accepted && wts[slot] >= stop_thr)
					stopped = 1'b1;
			end
			r.stored_weight = (slot >= 0) ? wts[slot] : '0;
			r.entry_count   = CNT_OUT_W'(held_cnt);
			r.stop_search   = stopped;
			return r;
		endfunction

		function void note_hit(hit_t h);
			n_hits++;
			if (h.category_id >= NUM_CATEGORIES)
				n_oor++;
			due_results.insert(due_results.size(), apply_hit(h));
		endfunction

		task report(string what, logic [WGT_W-1:0] e, logic [WGT_W-1:0] g);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch at result %0d, %s: expected %0h got %0h",
					n_results, what, e, g);
		endtask

		task check_result(res_t got);
			res_t e;
			if (due_results.size() == 0) begin
				report("result beat with nothing due", '0, got.stored_weight);
				return;
			end
			e = due_results.pop_front();
			n_results++;
			if (e.accepted)
				n_acc++;
			if (e.stop_search)
				n_stop++;
			if (got.accepted !== e.accepted)
				report("accepted", WGT_W'(e.accepted), WGT_W'(got.accepted));
			if (got.stored_weight !== e.stored_weight)
				report("stored_weight", e.stored_weight, got.stored_weight);
			if (got.entry_count !== e.entry_count)
				report("entry_count", WGT_W'(e.entry_count), WGT_W'(got.entry_count));
			if (got.overflow !== e.overflow)
				report("overflow", WGT_W'(e.overflow), WGT_W'(got.overflow));
			if (got.stop_search !== e.stop_search)
				report("stop_search", WGT_W'(e.stop_search), WGT_W'(got.stop_search));
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 hit_valid = 1'b0;
	logic                 hit_ready;
	hit_t                 hit       = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_en    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	hit_board sb = new();
	int       cycle_cnt = 0;
	int       cfg_writes = 0;
	bit       rx_calm = 1'b1;
	int       stall_left = 0;

	category_max_weight_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit       (hit),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res);
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// result side back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_cnt);
		$display("TB_ERROR");
		$finish;
	end

	task cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
		cfg_writes++;
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	// gap > 0 drops valid after the beat; gap sets how long it stays low
	task send_hit(bit ns, logic [ID_W-1:0] id, logic [WGT_W-1:0] w, int gap);
		hit_t h;
		h.new_search  = ns;
		h.category_id = id;
		h.weight      = w;
		@(negedge clk);
		hit       <= h;
		hit_valid <= 1'b1;
		do
			@(posedge clk);
		while (!hit_ready);
		sb.note_hit(h);
		if (gap > 0) begin
			@(negedge clk);
			hit_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// sender holds off until every due result has come back
	task drain(int extra);
		@(negedge clk);
		hit_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'd1;
			2:       return '1;
			3:       return $urandom_range(0, 200);
			4:       return sb.stop_thr + $urandom_range(0, 4) - 2;
			5, 6:    return $urandom_range(1, 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 99) < 85)
			return ID_W'($urandom_range(0, NUM_CATEGORIES - 1));
		return ID_W'($urandom_range(NUM_CATEGORIES, 255));
	endfunction

	initial begin
		logic [CFG_W-1:0] mask_word, thr_word;
		int               n_items;
		bit               calm;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: upper data bits must be masked off the enable register
		cfg_write(REG_ENABLED, 32'hFFFF_FFFF);
		send_hit(1'b1, 8'd0, 32'd0, 0);
		send_hit(1'b0, 8'd0, 32'd50, 1);
		send_hit(1'b0, 8'd0, 32'd30, 0);
		send_hit(1'b0, 8'd0, 32'd100, 2);
		send_hit(1'b0, 8'd9, 32'hFFFF_FFFF, 0);
		send_hit(1'b0, 8'd10, 32'd5, 0);
		send_hit(1'b0, 8'd255, 32'hFFFF_FFFF, 1);
		for (int i = 1; i < NUM_CATEGORIES - 1; i++)
			send_hit(1'b0, ID_W'(i), WGT_W'(i), 0);
		drain(4);
		cfg_write(REG_ENABLED, 32'hFFFF_FC05);
		cfg_write(REG_THRESHOLD, 32'd0);
		send_hit(1'b1, 8'd1, 32'd5, 0);
		send_hit(1'b0, 8'd2, 32'd1, 0);
		send_hit(1'b0, 8'd2, 32'd1, 0);
		drain(4);
		cfg_write(REG_THRESHOLD, 32'hFFFF_FFFF);
		send_hit(1'b1, 8'd0, 32'hFFFF_FFFE, 0);
		send_hit(1'b0, 8'd0, 32'hFFFF_FFFF, 0);
		send_hit(1'b0, 8'd3, 32'd7, 0);
		drain(4);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin mask_word = 32'h3FF; thr_word = 32'd100; n_items = 260; end
				1: begin mask_word = 32'h3FF; thr_word = 32'd0; n_items = 200; end
				2: begin mask_word = $urandom; thr_word = $urandom; n_items = 260; end
				3: begin mask_word = 32'h0; thr_word = $urandom; n_items = 30; end
				4: begin mask_word = 32'h3FF; thr_word = 32'hFFFF_FFFF; n_items = 260; end
				5: begin
					mask_word = $urandom;
					thr_word  = $urandom_range(1, 2000);
					n_items   = 260;
				end
				default: begin
					mask_word = ($urandom & 32'hFFFF_FC00) | 32'h2AA;
					thr_word  = 32'd100;
					n_items   = 200;
				end
			endcase
			cfg_write(REG_ENABLED, mask_word);
			cfg_write(REG_THRESHOLD, thr_word);
			for (int i = 0; i < n_items; i++) begin
				calm    = (i < 40);
				rx_calm = calm;
				if (i == n_items / 2)
					drain(0);
				send_hit($urandom_range(0, 24) == 0, pick_id(), pick_weight(),
					calm ? 0 : gap_len());
			end
			drain(4);
		end

		rx_calm = 1'b1;
		drain(25);

		$display("ran %0d hits through %0d register writes; %0d accepted, %0d with stop set",
			sb.n_hits, cfg_writes, sb.n_acc, sb.n_stop);
		$display("%0d hits carried out-of-range ids; %0d results checked, %0d mismatches",
			sb.n_oor, sb.n_results, sb.errors);
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cmwt_pkg.sv
rtl/cmwt_ram.sv
rtl/category_max_weight_table.sv
rtl/cmwt_checker.sv
tb/tb_category_max_weight_table.sv
